FILE: rtl/core/nmea_sentence_checksum_classifier_unit_defines.svh
// ----------------------------------------------------------------------------
// NMEA checksum classifier assertion macros
// Shared assertion macros for the sentence checksum classifier RTL.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKSUM_CLASSIFIER_UNIT_DEFINES_SVH
`define NMEA_SENTENCE_CHECKSUM_CLASSIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define NSCC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NSCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NSCC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define NSCC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/core/nscc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA checksum classifier package
// Character codes, sentence kind codes, header type and helper functions.
// ----------------------------------------------------------------------------
package nscc_pkg;

   localparam int HdrLen = 5;

   typedef logic [0:HdrLen-1][7:0] hdr_type;
   typedef logic [2:0] kind_type;

   localparam logic [7:0] CharStar   = 8'h2A;
   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharBang   = 8'h21;

   localparam logic [39:0] TagPflae = "PFLAE";
   localparam logic [39:0] TagPflau = "PFLAU";
   localparam logic [39:0] TagPflaa = "PFLAA";
   localparam logic [23:0] TagRmc   = "RMC";
   localparam logic [23:0] TagGga   = "GGA";
   localparam logic [23:0] TagRmz   = "RMZ";

   localparam kind_type KindOther = 3'd0;
   localparam kind_type KindPflae = 3'd1;
   localparam kind_type KindPflau = 3'd2;
   localparam kind_type KindPflaa = 3'd3;
   localparam kind_type KindRmc   = 3'd4;
   localparam kind_type KindGga   = 3'd5;
   localparam kind_type KindRmz   = 3'd6;

   localparam logic [4:0] HexNone = 5'd16;

   // Returns the digit value in the low four bits, or HexNone for a non-hex character.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         return {1'b0, d[3:0]};
      end
      if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
         return {1'b0, d[3:0]};
      end
      if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
         return {1'b0, d[3:0]};
      end
      return HexNone;
   endfunction

   function automatic kind_type classify(input hdr_type hdr);
      if (hdr == TagPflae) return KindPflae;
      if (hdr == TagPflau) return KindPflau;
      if (hdr == TagPflaa) return KindPflaa;
      if (hdr[2:4] == TagRmc) return KindRmc;
      if (hdr[2:4] == TagGga) return KindGga;
      if (hdr[2:4] == TagRmz) return KindRmz;
      return KindOther;
   endfunction

endpackage

FILE: rtl/core/nmea_sentence_checksum_classifier_unit.sv
// ----------------------------------------------------------------------------
// NMEA sentence checksum classifier
// Checks the XOR checksum of an NMEA sentence one byte per item and reports
// the sentence kind with the computed and received checksums.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  req_     | in        | one sentence byte and a last-byte flag
//  rsp_     | out       | one result per sentence, after its last byte
//
// One item is accepted per cycle; a result appears in the cycle after its
// last byte is taken. The single result register sets the rate: while it
// holds a result that is not taken, no item is accepted. Reset is
// synchronous and clears the sentence state and the result valid.
// ----------------------------------------------------------------------------
`include "nmea_sentence_checksum_classifier_unit_defines.svh"

module nmea_sentence_checksum_classifier_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_byte_in,
   input  logic                req_is_last,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output nscc_pkg::kind_type  rsp_sentence_kind,
   output logic                rsp_checksum_ok,
   output logic                rsp_star_seen,
   output logic [7:0]          rsp_computed_sum,
   output logic [7:0]          rsp_received_sum
);
   import nscc_pkg::*;

   logic [2:0] pos_ff, pos_in;
   hdr_type    hdr_ff, hdr_in;
   logic [7:0] xor_ff, xor_in;
   logic       star_ff, star_in;
   logic [1:0] hex_cnt_ff, hex_cnt_in;
   logic       hex_stop_ff, hex_stop_in;
   logic [7:0] rx_ff, rx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   kind_ff;
   logic       ok_ff, star_out_ff;
   logic [7:0] comp_ff, recv_ff;

   logic       accept;
   logic [4:0] hex_v;
   logic [2:0] hdr_idx;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign hex_v     = hex_value(req_byte_in);
   assign hdr_idx   = pos_ff - 3'd1;

   always_comb begin
      hdr_in      = hdr_ff;
      pos_in      = pos_ff;
      xor_in      = xor_ff;
      star_in     = star_ff;
      hex_cnt_in  = hex_cnt_ff;
      hex_stop_in = hex_stop_ff;
      rx_in       = rx_ff;
      if (pos_ff >= 3'd1 && pos_ff <= 3'd5) begin
         hdr_in[hdr_idx] = req_byte_in;
      end
      if (pos_ff < 3'd6) begin
         pos_in = pos_ff + 3'd1;
      end
      if (!star_ff) begin
         if (req_byte_in == CharStar) begin
            star_in = 1'b1;
         end else if (req_byte_in != CharDollar && req_byte_in != CharBang) begin
            xor_in = xor_ff ^ req_byte_in;
         end
      end else if (!hex_stop_ff) begin
         if (!hex_v[4]) begin
            rx_in      = {rx_ff[3:0], hex_v[3:0]};
            hex_cnt_in = hex_cnt_ff + 2'd1;
            if (hex_cnt_ff == 2'd1) begin
               hex_stop_in = 1'b1;
            end
         end else begin
            hex_stop_in = 1'b1;
         end
      end
   end

   assign rsp_valid_in = (accept && req_is_last) || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 3'd0;
         hdr_ff       <= '0;
         xor_ff       <= 8'd0;
         star_ff      <= 1'b0;
         hex_cnt_ff   <= 2'd0;
         hex_stop_ff  <= 1'b0;
         rx_ff        <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_is_last) begin
               pos_ff      <= 3'd0;
               hdr_ff      <= '0;
               xor_ff      <= 8'd0;
               star_ff     <= 1'b0;
               hex_cnt_ff  <= 2'd0;
               hex_stop_ff <= 1'b0;
               rx_ff       <= 8'd0;
            end else begin
               pos_ff      <= pos_in;
               hdr_ff      <= hdr_in;
               xor_ff      <= xor_in;
               star_ff     <= star_in;
               hex_cnt_ff  <= hex_cnt_in;
               hex_stop_ff <= hex_stop_in;
               rx_ff       <= rx_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_is_last) begin
         kind_ff     <= classify(hdr_in);
         ok_ff       <= star_in && (hex_cnt_in != 2'd0) && (rx_in == xor_in);
         star_out_ff <= star_in;
         comp_ff     <= xor_in;
         recv_ff     <= rx_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sentence_kind = kind_ff;
   assign rsp_checksum_ok   = ok_ff;
   assign rsp_star_seen     = star_out_ff;
   assign rsp_computed_sum  = comp_ff;
   assign rsp_received_sum  = recv_ff;

   `NSCC_ASSERT_SAME(a_no_take_on_stall, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready, "item taken while result stalled")
   `NSCC_ASSERT_NEXT(a_last_clears, clock, reset, accept && req_is_last, rsp_valid_ff && pos_ff == 3'd0 && !star_ff, "last item did not clear sentence state")
   `NSCC_ASSERT_SAME(a_ok_needs_star, clock, reset, rsp_valid_ff && ok_ff, star_out_ff, "checksum ok without star")
   `NSCC_ASSERT_SAME(a_no_star_no_sum, clock, reset, rsp_valid_ff && !star_out_ff, recv_ff == 8'd0, "received sum without star")
   `NSCC_ASSERT_SAME(a_two_digits_stop, clock, reset, hex_cnt_ff == 2'd2, hex_stop_ff && star_ff, "hex reading not stopped after two digits")

endmodule

FILE: bench/nmea_sentence_checksum_classifier_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence checksum classifier regression
// Streams sentence bytes into the classifier, predicts each sentence result
// in the bench, and compares every result field by field. Special sentences
// come first, then mostly well-formed random sentences mixed with noise,
// under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_classifier_unit_test;
   import nscc_pkg::*;

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned ByteTarget = 1100;

   typedef logic [7:0] byte_queue_t[$];

   typedef struct packed {
      kind_type   kind;
      logic       sum_ok;
      logic       star;
      logic [7:0] calc_sum;
      logic [7:0] rcvd_sum;
   } sentence_result_t;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_byte_in;
   logic       req_is_last;
   logic       rsp_valid;
   logic       rsp_ready;
   kind_type   rsp_sentence_kind;
   logic       rsp_checksum_ok;
   logic       rsp_star_seen;
   logic [7:0] rsp_computed_sum;
   logic [7:0] rsp_received_sum;

   sentence_result_t pending_results[$];
   sentence_result_t head_result;

   logic [7:0]  hdr_seen [5];
   int unsigned pos_next;
   logic [7:0]  xor_acc;
   logic        star_flag;
   int unsigned hex_count;
   logic        hex_done;
   logic [7:0]  rx_value;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned sentences_sent = 0;
   int unsigned results_checked = 0;
   int unsigned kind_hits [7];
   int unsigned burst_left = 0;
   logic [15:0] stall_pattern;
   int unsigned stall_idx;

   nmea_sentence_checksum_classifier_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_in       (req_byte_in),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sentence_kind (rsp_sentence_kind),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_star_seen     (rsp_star_seen),
      .rsp_computed_sum  (rsp_computed_sum),
      .rsp_received_sum  (rsp_received_sum)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("%0t ns: timed out after %0d cycles", $time, cycle_count);
         $display("nmea_sentence_checksum_classifier_unit regression: fail");
         $finish;
      end
   end

   // The receiver replays a 16-bit ready pattern and periodically replaces it with a new random one or with all ones.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_idx <= 0;
         stall_pattern <= 16'hFFFF;
      end else begin
         rsp_ready <= stall_pattern[stall_idx % 16];
         stall_idx <= stall_idx + 1;
         if (stall_idx % 64 == 63) begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
         end
      end
   end

   function automatic void clear_prediction();
      foreach (hdr_seen[i]) hdr_seen[i] = 8'h00;
      pos_next = 0;
      xor_acc = 8'h00;
      star_flag = 1'b0;
      hex_count = 0;
      hex_done = 1'b0;
      rx_value = 8'h00;
   endfunction

   function automatic int hex_digit_value(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
      return -1;
   endfunction

   function automatic kind_type sentence_kind_of();
      logic [39:0] hdr;
      hdr = {hdr_seen[0], hdr_seen[1], hdr_seen[2], hdr_seen[3], hdr_seen[4]};
      if (hdr == TagPflae) return KindPflae;
      if (hdr == TagPflau) return KindPflau;
      if (hdr == TagPflaa) return KindPflaa;
      if (hdr[23:0] == TagRmc) return KindRmc;
      if (hdr[23:0] == TagGga) return KindGga;
      if (hdr[23:0] == TagRmz) return KindRmz;
      return KindOther;
   endfunction

   function automatic void predict_byte(logic [7:0] c, logic is_final);
      sentence_result_t r;
      int digit;
      if (pos_next >= 1 && pos_next <= 5) hdr_seen[pos_next - 1] = c;
      if (pos_next < 6) pos_next++;
      if (!star_flag) begin
         if (c == CharStar) star_flag = 1'b1;
         else if (c != CharDollar && c != CharBang) xor_acc ^= c;
      end else if (!hex_done) begin
         digit = hex_digit_value(c);
         if (digit >= 0) begin
            rx_value = {rx_value[3:0], 4'(digit)};
            hex_count++;
            if (hex_count >= 2) hex_done = 1'b1;
         end else begin
            hex_done = 1'b1;
         end
      end
      if (is_final) begin
         r.kind = sentence_kind_of();
         r.sum_ok = star_flag && hex_count > 0 && rx_value == xor_acc;
         r.star = star_flag;
         r.calc_sum = xor_acc;
         r.rcvd_sum = rx_value;
         pending_results.push_back(r);
         clear_prediction();
      end
   endfunction

   function automatic void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
      end
   endfunction

   // Outputs are stable between edges, so the handshake is sampled at the falling edge.
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t ns: result with no sentence pending, expected none, got kind %0d",
                     $time, rsp_sentence_kind);
         end else begin
            head_result = pending_results.pop_front();
            check_field("sentence_kind", head_result.kind, rsp_sentence_kind);
            check_field("checksum_ok", head_result.sum_ok, rsp_checksum_ok);
            check_field("star_seen", head_result.star, rsp_star_seen);
            check_field("computed_sum", head_result.calc_sum, rsp_computed_sum);
            check_field("received_sum", head_result.rcvd_sum, rsp_received_sum);
            results_checked++;
            kind_hits[head_result.kind]++;
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic is_final);
      int unsigned gap;
      logic taken;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_byte_in <= value;
      req_is_last <= is_final;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      predict_byte(value, is_final);
      bytes_sent++;
      if (is_final) sentences_sent++;
   endtask

   task automatic send_sentence(input byte_queue_t text);
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic byte_queue_t text_bytes(string s);
      byte_queue_t q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   function automatic logic [7:0] random_upper();
      return 8'h41 + 8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nibble);
      if (nibble < 10) return 8'h30 + 8'(nibble);
      return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + 8'(nibble) - 8'd10;
   endfunction

   task automatic send_random_sentence();
      byte_queue_t text;
      logic [39:0] tag;
      logic [7:0] sum;
      logic [7:0] c;
      string noise_chars;
      noise_chars = "$!*09afAFGRMCZ,";
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 2))
            0: text.push_back(CharDollar);
            1: text.push_back(CharBang);
            default: text.push_back(random_upper());
         endcase
         case ($urandom_range(0, 6))
            0: tag = TagPflae;
            1: tag = TagPflau;
            2: tag = TagPflaa;
            3: tag = {random_upper(), random_upper(), TagRmc};
            4: tag = {random_upper(), random_upper(), TagGga};
            5: tag = {random_upper(), random_upper(), TagRmz};
            default: tag = {random_upper(), random_upper(), random_upper(),
                            random_upper(), random_upper()};
         endcase
         if ($urandom_range(0, 7) == 0) tag[8 * $urandom_range(0, 4) +: 8] = random_upper();
         for (int i = 4; i >= 0; i--) text.push_back(tag[8 * i +: 8]);
         text.push_back(8'h2C);
         repeat ($urandom_range(0, 10)) begin
            c = 8'($urandom_range(32, 126));
            if (c == CharStar || c == CharDollar || c == CharBang) c = 8'h2C;
            text.push_back(c);
         end
         sum = 8'h00;
         foreach (text[i]) if (text[i] != CharDollar && text[i] != CharBang) sum ^= text[i];
         if ($urandom_range(0, 7) == 0) sum ^= 8'($urandom_range(1, 255));
         text.push_back(CharStar);
         text.push_back(hex_char(sum[7:4]));
         text.push_back(hex_char(sum[3:0]));
         if ($urandom_range(0, 5) == 0) begin
            text.push_back(8'h0D);
            text.push_back(8'h0A);
         end
      end else begin
         repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 2) == 0) text.push_back(8'($urandom_range(0, 255)));
            else text.push_back(noise_chars[$urandom_range(0, noise_chars.len() - 1)]);
         end
      end
      send_sentence(text);
   endtask

   task automatic test_special_cases();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_sentence(text_bytes("*"));
      send_sentence(text_bytes("A*41"));
      send_sentence(text_bytes("$PFLAE*5e"));
      send_sentence(text_bytes("b*Z1*"));
      send_sentence(text_bytes("1*311"));
   endtask

   task automatic test_random_traffic(input int unsigned byte_goal);
      while (bytes_sent < byte_goal) send_random_sentence();
   endtask

   task automatic test_restart_after_drain();
      wait_drained();
      repeat (3) send_random_sentence();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_byte_in = 8'h00;
      req_is_last = 1'b0;
      foreach (kind_hits[i]) kind_hits[i] = 0;
      clear_prediction();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_special_cases();
      test_random_traffic(ByteTarget / 2);
      test_restart_after_drain();
      test_random_traffic(ByteTarget);
      wait_drained();

      $display("Sent %0d bytes in %0d sentences and checked %0d results.",
               bytes_sent, sentences_sent, results_checked);
      $display("Kinds other/PFLAE/PFLAU/PFLAA/RMC/GGA/RMZ: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
               kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3],
               kind_hits[4], kind_hits[5], kind_hits[6]);
      if (error_count == 0) begin
         $display("nmea_sentence_checksum_classifier_unit regression: pass");
      end else begin
         $display("nmea_sentence_checksum_classifier_unit regression: fail");
      end
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/nscc_pkg.sv
rtl/core/nmea_sentence_checksum_classifier_unit.sv
bench/nmea_sentence_checksum_classifier_unit_test.sv
